/* hw/rtl/ghcb_pkg.sv */
// ----------------------------------------------------------------------------
// ghcb_pkg
// Shared types, codes and elaboration-time table builders for the color
// boost pipeline (gamma decode table, gamma encode thresholds).
// ----------------------------------------------------------------------------
package ghcb_pkg;

	localparam int unsigned TAB_W     = 17;	// holds 2^16 for the widest format
	localparam int unsigned GAIN_W    = 10;
	localparam int unsigned GAIN_FRAC = 8;
	localparam int unsigned ENC_STEPS = 8;	// one output code bit per step

	localparam logic [GAIN_W-1:0] SAT_GAIN_RST = 10'd307;
	localparam logic [GAIN_W-1:0] VAL_GAIN_RST = 10'd512;

	// register indexes
	localparam logic REG_SAT_GAIN = 1'b0;
	localparam logic REG_VAL_GAIN = 1'b1;

	// channel holding the maximum
	localparam logic [1:0] HSEL_RED   = 2'd0;
	localparam logic [1:0] HSEL_GREEN = 2'd1;
	localparam logic [1:0] HSEL_BLUE  = 2'd2;

	// hue sectors
	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

	typedef logic [TAB_W-1:0] tab_t [256];
	typedef logic [255:0] big_t;

	typedef struct packed {
		logic [1:0] hsel;
		logic       neg;
		logic       d_zero;
		logic       m_zero;
	} hue_ctl_t;

	function automatic big_t big_pow(big_t base, int unsigned n);
		big_t acc;
		acc = big_t'(1);
		for (int unsigned i = 0; i < n; i++)
			acc = acc * base;
		return acc;
	endfunction

	// largest y with (y/2^f)^5 <= (k/255)^11, exact
	function automatic tab_t build_lin_tab(int unsigned f);
		tab_t        tab;
		big_t        one_p, c_p, rhs;
		int unsigned lo, hi, mid;
		one_p = big_pow(big_t'(1) << f, 5);
		c_p   = big_pow(big_t'(255), 11);
		for (int unsigned k = 0; k < 256; k++) begin
			rhs = big_pow(big_t'(k), 11) * one_p;
			lo  = 0;
			hi  = 1 << f;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				if (big_pow(big_t'(mid), 5) * c_p <= rhs) lo = mid;
				else hi = mid - 1;
			end
			tab[k] = TAB_W'(lo);
		end
		return tab;
	endfunction

	// smallest v with (v/2^f)^5 >= (k/255)^13, exact
	function automatic tab_t build_thr_tab(int unsigned f);
		tab_t        tab;
		big_t        one_p, c_p, rhs;
		int unsigned lo, hi, mid;
		one_p = big_pow(big_t'(1) << f, 5);
		c_p   = big_pow(big_t'(255), 13);
		for (int unsigned k = 0; k < 256; k++) begin
			rhs = big_pow(big_t'(k), 13) * one_p;
			lo  = 0;
			hi  = 1 << f;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (big_pow(big_t'(mid), 5) * c_p >= rhs) hi = mid;
				else lo = mid + 1;
			end
			tab[k] = TAB_W'(lo);
		end
		return tab;
	endfunction

endpackage

/* hw/rtl/ghcb_front.sv */
// ----------------------------------------------------------------------------
// ghcb_front
// Gamma decode of the three channels, then max/min, chroma and the hue
// numerator that feed the dividers.
// ----------------------------------------------------------------------------
module ghcb_front import ghcb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	output logic                 out_vld,
	output logic [FRAC_BITS:0]   mx,
	output logic [FRAC_BITS:0]   chroma,
	output logic [FRAC_BITS:0]   mag,
	output hue_ctl_t             ctl
);

	localparam tab_t LIN_TAB = build_lin_tab(FRAC_BITS);

	logic                 vld_s1, vld_s2;
	logic [FRAC_BITS:0]   r_s1, g_s1, b_s1;
	logic [FRAC_BITS:0]   mx_s2, d_s2, mag_s2;
	hue_ctl_t             ctl_s2;

	logic [FRAC_BITS:0]   mx_c, mn_c, mag_c;
	hue_ctl_t             ctl_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: linearize
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= LIN_TAB[red][FRAC_BITS:0];
			g_s1 <= LIN_TAB[green][FRAC_BITS:0];
			b_s1 <= LIN_TAB[blue][FRAC_BITS:0];
		end
	end

	// stage 2: max, min, hue numerator and sign
	always_comb begin
		mx_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		mn_c = r_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;

		ctl_c.m_zero = (mx_c == '0);
		ctl_c.d_zero = (mx_c == mn_c);
		priority if (mx_c == r_s1) begin
			ctl_c.hsel = HSEL_RED;
			ctl_c.neg  = (g_s1 < b_s1);
			mag_c      = ctl_c.neg ? b_s1 - g_s1 : g_s1 - b_s1;
		end else if (mx_c == g_s1) begin
			ctl_c.hsel = HSEL_GREEN;
			ctl_c.neg  = (b_s1 < r_s1);
			mag_c      = ctl_c.neg ? r_s1 - b_s1 : b_s1 - r_s1;
		end else begin
			ctl_c.hsel = HSEL_BLUE;
			ctl_c.neg  = (r_s1 < g_s1);
			mag_c      = ctl_c.neg ? g_s1 - r_s1 : r_s1 - g_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2  <= mx_c;
			d_s2   <= mx_c - mn_c;
			mag_s2 <= mag_c;
			ctl_s2 <= ctl_c;
		end
	end

	assign out_vld = vld_s2;
	assign mx      = mx_s2;
	assign chroma  = d_s2;
	assign mag     = mag_s2;
	assign ctl     = ctl_s2;

endmodule

/* hw/rtl/ghcb_div.sv */
// ----------------------------------------------------------------------------
// ghcb_div
// Two-lane pipelined restoring divider: quo = (num << FRAC_BITS) / den for
// num <= den, one quotient bit per stage, with a sideband that travels along.
// ----------------------------------------------------------------------------
module ghcb_div import ghcb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12,
	parameter int unsigned SB_W      = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [1:0][FRAC_BITS:0]    num,
	input  logic [1:0][FRAC_BITS:0]    den,
	input  logic [SB_W-1:0]            sb_in,
	output logic                       out_vld,
	output logic [1:0][FRAC_BITS:0]    quo,
	output logic [SB_W-1:0]            sb_out
);

	localparam int unsigned NS = FRAC_BITS + 1;
	localparam int unsigned RW = FRAC_BITS + 2;
	localparam int unsigned QW = FRAC_BITS + 1;

	logic [RW-1:0]      rem_s [NS][2];
	logic [QW-1:0]      den_s [NS][2];
	logic [QW-1:0]      quo_s [NS][2];
	logic [SB_W-1:0]    sb_s  [NS];
	logic [NS-1:0]      vld_s;

	logic [RW-1:0]      r_in  [NS][2];
	logic [QW-1:0]      d_in  [NS][2];
	logic [QW-1:0]      q_in  [NS][2];
	logic [SB_W-1:0]    sb_nx [NS];
	logic [NS-1:0]      v_in;
	logic [RW-1:0]      r_nx  [NS][2];
	logic [QW-1:0]      q_nx  [NS][2];

	// stage inputs
	always_comb begin
		v_in[0]  = in_vld;
		sb_nx[0] = sb_in;
		for (int l = 0; l < 2; l++) begin
			r_in[0][l] = RW'(num[l]);
			d_in[0][l] = den[l];
			q_in[0][l] = '0;
		end
		for (int j = 1; j < NS; j++) begin
			v_in[j]  = vld_s[j-1];
			sb_nx[j] = sb_s[j-1];
			for (int l = 0; l < 2; l++) begin
				r_in[j][l] = rem_s[j-1][l];
				d_in[j][l] = den_s[j-1][l];
				q_in[j][l] = quo_s[j-1][l];
			end
		end
	end

	// one compare and subtract per stage
	always_comb begin
		logic ge;
		for (int j = 0; j < NS; j++) begin
			for (int l = 0; l < 2; l++) begin
				ge         = (r_in[j][l] >= RW'(d_in[j][l]));
				r_nx[j][l] = (ge ? r_in[j][l] - RW'(d_in[j][l]) : r_in[j][l]) << 1;
				q_nx[j][l] = q_in[j][l] | (ge ? QW'(1) << (FRAC_BITS - j) : QW'(0));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NS; j++) begin
				sb_s[j] <= sb_nx[j];
				for (int l = 0; l < 2; l++) begin
					rem_s[j][l] <= r_nx[j][l];
					den_s[j][l] <= d_in[j][l];
					quo_s[j][l] <= q_nx[j][l];
				end
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign quo[0]  = quo_s[NS-1][0];
	assign quo[1]  = quo_s[NS-1][1];
	assign sb_out  = sb_s[NS-1];

endmodule

/* hw/rtl/ghcb_back.sv */
// ----------------------------------------------------------------------------
// ghcb_back
// Hue assembly, gain scaling with clamp, and HSV to RGB by sector and
// fraction. Four register stages.
// ----------------------------------------------------------------------------
module ghcb_back import ghcb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [FRAC_BITS:0]         sat_quo,
	input  logic [FRAC_BITS:0]         hue_quo,
	input  logic [FRAC_BITS:0]         mx,
	input  hue_ctl_t                   ctl,
	input  logic [GAIN_W-1:0]          sat_gain,
	input  logic [GAIN_W-1:0]          val_gain,
	output logic                       out_vld,
	output logic [2:0][FRAC_BITS:0]    rgb
);

	localparam int unsigned VW = FRAC_BITS + 1;
	localparam int unsigned HW = FRAC_BITS + 3;
	localparam int unsigned PW = FRAC_BITS + 1 + GAIN_W;
	localparam int unsigned MW = 2 * FRAC_BITS + 2;
	localparam logic [VW-1:0] ONE   = VW'(1) << FRAC_BITS;
	localparam logic [HW-1:0] ONE_H = HW'(1) << FRAC_BITS;
	localparam logic [HW-1:0] TWO_H = HW'(2) << FRAC_BITS;
	localparam logic [HW-1:0] FOUR_H = HW'(4) << FRAC_BITS;
	localparam logic [HW-1:0] SIX_H = HW'(6) << FRAC_BITS;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0]           sect_s1, sect_s2, sect_s3;
	logic [FRAC_BITS-1:0] frac_s1;
	logic [PW-1:0]        ps_s1, pv_s1;
	logic [VW-1:0]        sv_s2, vv_s2, vv_s3, o_s3, p_s3, q_s3;
	logic [MW-1:0]        m1_s2, m2_s2;
	logic [2:0][VW-1:0]   rgb_s4;

	logic [HW-1:0]        base_c, h6_c;
	logic [2:0]           sect_c;
	logic [FRAC_BITS-1:0] frac_c;
	logic [VW-1:0]        s_c, sv_c, vv_c;
	logic [MW-1:0]        po_c, pp_c, pq_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: hue times six, sector split, gain products
	always_comb begin
		unique case (ctl.hsel)
			HSEL_RED:   base_c = ctl.neg ? SIX_H : '0;
			HSEL_GREEN: base_c = TWO_H;
			default:    base_c = FOUR_H;
		endcase
		if (ctl.d_zero) h6_c = '0;
		else if (ctl.neg) h6_c = base_c - HW'(hue_quo);
		else h6_c = base_c + HW'(hue_quo);

		sect_c = h6_c[HW-1:FRAC_BITS];
		frac_c = h6_c[FRAC_BITS-1:0];
		// full turn wraps to the first sector
		if (sect_c > SEC_MR) begin
			sect_c = SEC_RY;
			frac_c = '0;
		end
		s_c = ctl.m_zero ? '0 : sat_quo;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sect_s1 <= sect_c;
			frac_s1 <= frac_c;
			ps_s1   <= PW'(s_c) * PW'(sat_gain);
			pv_s1   <= PW'(mx) * PW'(val_gain);
		end
	end

	// stage 2: clamp to one, saturation times fraction
	always_comb begin
		sv_c = (ps_s1[PW-1:GAIN_FRAC] > (PW-GAIN_FRAC)'(ONE)) ? ONE
			: ps_s1[GAIN_FRAC+VW-1:GAIN_FRAC];
		vv_c = (pv_s1[PW-1:GAIN_FRAC] > (PW-GAIN_FRAC)'(ONE)) ? ONE
			: pv_s1[GAIN_FRAC+VW-1:GAIN_FRAC];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sect_s2 <= sect_s1;
			sv_s2   <= sv_c;
			vv_s2   <= vv_c;
			m1_s2   <= MW'(sv_c) * MW'(frac_s1);
			m2_s2   <= MW'(sv_c) * MW'(ONE - VW'(frac_s1));
		end
	end

	// stage 3: o, p, q
	always_comb begin
		po_c = MW'(vv_s2) * MW'(ONE - sv_s2);
		pp_c = MW'(vv_s2) * MW'(ONE - m1_s2[2*FRAC_BITS:FRAC_BITS]);
		pq_c = MW'(vv_s2) * MW'(ONE - m2_s2[2*FRAC_BITS:FRAC_BITS]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sect_s3 <= sect_s2;
			vv_s3   <= vv_s2;
			o_s3    <= po_c[2*FRAC_BITS:FRAC_BITS];
			p_s3    <= pp_c[2*FRAC_BITS:FRAC_BITS];
			q_s3    <= pq_c[2*FRAC_BITS:FRAC_BITS];
		end
	end

	// stage 4: channel assignment by sector
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (sect_s3)
				SEC_YG:  rgb_s4 <= {o_s3, vv_s3, p_s3};
				SEC_GC:  rgb_s4 <= {q_s3, vv_s3, o_s3};
				SEC_CB:  rgb_s4 <= {vv_s3, p_s3, o_s3};
				SEC_BM:  rgb_s4 <= {vv_s3, o_s3, q_s3};
				SEC_MR:  rgb_s4 <= {p_s3, o_s3, vv_s3};
				default: rgb_s4 <= {o_s3, q_s3, vv_s3};
			endcase
		end
	end

	assign out_vld = vld_s4;
	assign rgb     = rgb_s4;

endmodule

/* hw/rtl/ghcb_enc.sv */
// ----------------------------------------------------------------------------
// ghcb_enc
// Gamma encode of three linear channels: binary search over the threshold
// table, one code bit per stage, eight stages.
// ----------------------------------------------------------------------------
module ghcb_enc import ghcb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [2:0][FRAC_BITS:0]    lin,
	output logic                       out_vld,
	output logic [2:0][7:0]            code
);

	localparam tab_t THR_TAB = build_thr_tab(FRAC_BITS);

	logic [FRAC_BITS:0]   x_s  [ENC_STEPS][3];
	logic [7:0]           n_s  [ENC_STEPS][3];
	logic [ENC_STEPS-1:0] vld_s;

	logic [FRAC_BITS:0]   x_in [ENC_STEPS][3];
	logic [7:0]           n_in [ENC_STEPS][3];
	logic [7:0]           n_nx [ENC_STEPS][3];
	logic [ENC_STEPS-1:0] v_in;

	always_comb begin
		v_in[0] = in_vld;
		for (int l = 0; l < 3; l++) begin
			x_in[0][l] = lin[l];
			n_in[0][l] = '0;
		end
		for (int j = 1; j < ENC_STEPS; j++) begin
			v_in[j] = vld_s[j-1];
			for (int l = 0; l < 3; l++) begin
				x_in[j][l] = x_s[j-1][l];
				n_in[j][l] = n_s[j-1][l];
			end
		end
	end

	// try the next lower code bit against its threshold
	always_comb begin
		logic [7:0] cand;
		for (int j = 0; j < ENC_STEPS; j++) begin
			for (int l = 0; l < 3; l++) begin
				cand       = n_in[j][l] | (8'd1 << (ENC_STEPS - 1 - j));
				n_nx[j][l] = (THR_TAB[cand][FRAC_BITS:0] <= x_in[j][l]) ? cand : n_in[j][l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < ENC_STEPS; j++) begin
				for (int l = 0; l < 3; l++) begin
					x_s[j][l] <= x_in[j][l];
					n_s[j][l] <= n_nx[j][l];
				end
			end
		end
	end

	assign out_vld = vld_s[ENC_STEPS-1];
	assign code[0] = n_s[ENC_STEPS-1][0];
	assign code[1] = n_s[ENC_STEPS-1][1];
	assign code[2] = n_s[ENC_STEPS-1][2];

endmodule

/* hw/rtl/gamma_hsv_color_boost.sv */
// ----------------------------------------------------------------------------
// gamma_hsv_color_boost
// Gamma-aware saturation and brightness boost of 8-bit RGB colors in HSV.
//
// Takes one color per clock and returns one corrected color per clock as
// long as the output side takes results. Each color passes two front-end
// stages (gamma decode, then max/min), one divider stage per quotient bit
// (FRAC_BITS + 1), four HSV-to-RGB stages, eight encode stages and the
// output buffer. A two-entry output buffer decouples in_ready from
// out_ready. Gains are Q2.8 and may only be written while no color is
// in flight.
// ----------------------------------------------------------------------------
module gamma_hsv_color_boost import ghcb_pkg::*; #(
	parameter int unsigned FRAC_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic                 cfg_idx,
	input  logic [GAIN_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           red_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           blue_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out
);

	localparam int unsigned VW   = FRAC_BITS + 1;
	localparam int unsigned SB_W = $bits(hue_ctl_t) + VW;

	logic [GAIN_W-1:0]   sat_gain_q, val_gain_q;
	logic                en;

	logic                fr_vld, dv_vld, bk_vld, en_vld;
	logic [VW-1:0]       fr_mx, fr_d, fr_mag, dv_mx;
	hue_ctl_t            fr_ctl, dv_ctl;
	logic [1:0][VW-1:0]  dv_num, dv_den, dv_quo;
	logic [SB_W-1:0]     dv_sb;
	logic [2:0][VW-1:0]  bk_rgb;
	logic [2:0][7:0]     en_code;

	logic [2:0][7:0]     buf_q [2];
	logic                wr_q, rd_q;
	logic [1:0]          cnt_q;
	logic                push, pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_gain_q <= SAT_GAIN_RST;
			val_gain_q <= VAL_GAIN_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_SAT_GAIN: sat_gain_q <= cfg_data;
				REG_VAL_GAIN: val_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves whenever the output buffer has a free slot
	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;

	ghcb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.red     (red_in),
		.green   (green_in),
		.blue    (blue_in),
		.out_vld (fr_vld),
		.mx      (fr_mx),
		.chroma  (fr_d),
		.mag     (fr_mag),
		.ctl     (fr_ctl)
	);

	// lane 0: saturation = d / max, lane 1: hue fraction = |diff| / d
	assign dv_num[0] = fr_d;
	assign dv_den[0] = fr_mx;
	assign dv_num[1] = fr_mag;
	assign dv_den[1] = fr_d;

	ghcb_div #(.FRAC_BITS(FRAC_BITS), .SB_W(SB_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (fr_vld),
		.num     (dv_num),
		.den     (dv_den),
		.sb_in   ({fr_ctl, fr_mx}),
		.out_vld (dv_vld),
		.quo     (dv_quo),
		.sb_out  (dv_sb)
	);

	assign dv_ctl = dv_sb[SB_W-1:VW];
	assign dv_mx  = dv_sb[VW-1:0];

	ghcb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (dv_vld),
		.sat_quo  (dv_quo[0]),
		.hue_quo  (dv_quo[1]),
		.mx       (dv_mx),
		.ctl      (dv_ctl),
		.sat_gain (sat_gain_q),
		.val_gain (val_gain_q),
		.out_vld  (bk_vld),
		.rgb      (bk_rgb)
	);

	ghcb_enc #(.FRAC_BITS(FRAC_BITS)) u_enc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (bk_vld),
		.lin     (bk_rgb),
		.out_vld (en_vld),
		.code    (en_code)
	);

	// two-entry output buffer
	assign push = en && en_vld;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= en_code;
	end

	assign out_valid = (cnt_q != 2'd0);
	assign red_out   = buf_q[rd_q][0];
	assign green_out = buf_q[rd_q][1];
	assign blue_out  = buf_q[rd_q][2];

	// a pushed color is visible on the next cycle
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid)
		else $error("pushed color not presented");

	// buffer never overfills
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer overflow");

	// saturation gain write takes effect
	a_cfg_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wen && cfg_idx == REG_SAT_GAIN) |=> sat_gain_q == $past(cfg_data))
		else $error("saturation gain write lost");

endmodule

/* tb/gamma_hsv_color_boost_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gamma_hsv_color_boost_tb
// Self-checking bench for the gamma-aware HSV color boost.
//
// Colors are sent through the valid/ready input in random bursts while the
// output side stalls on its own pattern. A bit-exact predictor (own gamma
// tables, HSV math, gain clamps) computes the expected colors bar those
// typed in for the first setting; results are checked in order. Several
// gain settings, extremes included, each get directed and random colors.
// ----------------------------------------------------------------------------
module gamma_hsv_color_boost_tb;
	import ghcb_pkg::*;

	localparam int unsigned FRAC   = 12;
	localparam int unsigned ONE    = 1 << FRAC;
	localparam int unsigned DRAIN  = 40;	// pipeline depth plus margin
	localparam int unsigned N_RAND = 300;	// random colors per gain setting

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct {
		rgb_t color;
		bit   known;	// expected color typed in below
		rgb_t want;
	} color_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic              cfg_idx = REG_SAT_GAIN;
	logic [GAIN_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        red_in = '0, green_in = '0, blue_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        red_out, green_out, blue_out;

	int unsigned decode_lut [256];
	int unsigned encode_thr [256];
	int unsigned sat_gain = 307;
	int unsigned val_gain = 512;
	rgb_t        pending_colors [$];
	int          errors = 0;
	int          n_checked = 0;
	int          n_sent = 0;
	int          burst_left = 0;

	gamma_hsv_color_boost #(.FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("timeout: %0d colors still pending", pending_colors.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [255:0] ipow(logic [255:0] base, int n);
		logic [255:0] acc;
		acc = 1;
		repeat (n) acc = acc * base;
		return acc;
	endfunction

	// exact power tables: decode y^5 <= (k/255)^11, encode v^5 >= (k/255)^13
	task automatic build_gamma_luts();
		logic [255:0] scale5;
		int unsigned  lo, hi, mid;
		scale5 = ipow(ONE, 5);
		for (int k = 0; k < 256; k++) begin
			lo = 0;
			hi = ONE;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				if (ipow(mid, 5) * ipow(255, 11) <= ipow(k, 11) * scale5) lo = mid;
				else hi = mid - 1;
			end
			decode_lut[k] = lo;
			lo = 0;
			hi = ONE;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (ipow(mid, 5) * ipow(255, 13) >= ipow(k, 13) * scale5) hi = mid;
				else lo = mid + 1;
			end
			encode_thr[k] = lo;
		end
	endtask

	function automatic logic [7:0] gamma_encode(longint unsigned x);
		int n;
		n = 0;
		for (int k = 1; k < 256; k++)
			if (encode_thr[k] <= x) n++;
		return n[7:0];
	endfunction

	// boosted color for one input at the current gains
	function automatic rgb_t boost_color(rgb_t c);
		longint unsigned r, g, b, mx, mn, d, s, h6, qv, sv, vv, sec, frac, o, p, q, t;
		rgb_t res;
		r = decode_lut[c.r];
		g = decode_lut[c.g];
		b = decode_lut[c.b];
		mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
		mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
		d = mx - mn;
		s = 0;
		h6 = 0;
		if (mx != 0) begin
			s = (d << FRAC) / mx;
			if (d != 0) begin
				if (mx == r) begin
					qv = ((g >= b ? g - b : b - g) << FRAC) / d;
					h6 = (g < b) ? 6 * ONE - qv : qv;
				end else if (mx == g) begin
					qv = ((b >= r ? b - r : r - b) << FRAC) / d;
					h6 = (b < r) ? 2 * ONE - qv : 2 * ONE + qv;
				end else begin
					qv = ((r >= g ? r - g : g - r) << FRAC) / d;
					h6 = (r < g) ? 4 * ONE - qv : 4 * ONE + qv;
				end
			end
		end
		t = (s * sat_gain) >> 8;
		sv = (t > ONE) ? ONE : t;
		t = (mx * val_gain) >> 8;
		vv = (t > ONE) ? ONE : t;
		sec = h6 >> FRAC;
		frac = h6 & (ONE - 1);
		if (sec >= 6) begin
			sec = 0;
			frac = 0;
		end
		o = (vv * (ONE - sv)) >> FRAC;
		p = (vv * (ONE - ((sv * frac) >> FRAC))) >> FRAC;
		q = (vv * (ONE - ((sv * (ONE - frac)) >> FRAC))) >> FRAC;
		case (sec)
			1: begin res.r = gamma_encode(p); res.g = gamma_encode(vv); res.b = gamma_encode(o); end
			2: begin res.r = gamma_encode(o); res.g = gamma_encode(vv); res.b = gamma_encode(q); end
			3: begin res.r = gamma_encode(o); res.g = gamma_encode(p); res.b = gamma_encode(vv); end
			4: begin res.r = gamma_encode(q); res.g = gamma_encode(o); res.b = gamma_encode(vv); end
			5: begin res.r = gamma_encode(vv); res.g = gamma_encode(o); res.b = gamma_encode(p); end
			default: begin
				res.r = gamma_encode(vv); res.g = gamma_encode(q); res.b = gamma_encode(o);
			end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string chan, logic [7:0] want, logic [7:0] got);
		$display("t=%0t %s mismatch: expected %0d got %0d", $realtime, chan, want, got);
		errors++;
	endtask

	// output side: check each transaction, stall on a rotating pattern
	always @(posedge clk) begin
		rgb_t want;
		int   mode;
		if (arst_n && out_valid && out_ready) begin
			if (pending_colors.size() == 0) begin
				$display("t=%0t unexpected color %0d %0d %0d", $realtime,
					red_out, green_out, blue_out);
				errors++;
			end else begin
				want = pending_colors.pop_front();
				if (red_out !== want.r) report_mismatch("red", want.r, red_out);
				if (green_out !== want.g) report_mismatch("green", want.g, green_out);
				if (blue_out !== want.b) report_mismatch("blue", want.b, blue_out);
				n_checked++;
			end
		end
		mode = ($realtime / 20 / 128);
		case (mode % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// one input transaction, with bursts and random gaps in between
	task automatic send_color(rgb_t c, rgb_t want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		red_in <= c.r;
		green_in <= c.g;
		blue_in <= c.b;
		do @(posedge clk); while (!in_ready);
		pending_colors.push_back(want);
		burst_left--;
		n_sent++;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_gains(int unsigned sg, int unsigned vg);
		cfg_wen <= 1'b1;
		cfg_idx <= REG_SAT_GAIN;
		cfg_data <= sg[GAIN_W-1:0];
		@(posedge clk);
		cfg_idx <= REG_VAL_GAIN;
		cfg_data <= vg[GAIN_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		sat_gain = sg;
		val_gain = vg;
	endtask

	initial begin
		color_row_t  rows [$];
		int unsigned gains [6][2];
		rgb_t        c;
		rgb_t        want;

		build_gamma_luts();
		// primaries, yellow, magenta and black/white have obvious results at reset gains
		rows = '{
			'{'{8'd0, 8'd0, 8'd0}, 1, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd255, 8'd255, 8'd255}, 1, '{8'd255, 8'd255, 8'd255}},
			'{'{8'd255, 8'd0, 8'd0}, 1, '{8'd255, 8'd0, 8'd0}},
			'{'{8'd0, 8'd255, 8'd0}, 1, '{8'd0, 8'd255, 8'd0}},
			'{'{8'd0, 8'd0, 8'd255}, 1, '{8'd0, 8'd0, 8'd255}},
			'{'{8'd255, 8'd255, 8'd0}, 1, '{8'd255, 8'd255, 8'd0}},
			'{'{8'd255, 8'd0, 8'd255}, 1, '{8'd255, 8'd0, 8'd255}},
			'{'{8'd0, 8'd255, 8'd255}, 0, '0},
			'{'{8'd1, 8'd1, 8'd1}, 0, '0},
			'{'{8'd128, 8'd128, 8'd128}, 0, '0},
			'{'{8'd255, 8'd10, 8'd11}, 0, '0},	// hue just below wrap
			'{'{8'd255, 8'd11, 8'd10}, 0, '0},
			'{'{8'd10, 8'd255, 8'd200}, 0, '0},
			'{'{8'd200, 8'd10, 8'd255}, 0, '0},
			'{'{8'd170, 8'd85, 8'd51}, 0, '0},
			'{'{8'd1, 8'd0, 8'd0}, 0, '0},
			'{'{8'd254, 8'd253, 8'd1}, 0, '0},
			'{'{8'd85, 8'd170, 8'd170}, 0, '0}
		};
		gains = '{'{307, 512}, '{0, 0}, '{1023, 1023}, '{0, 1023},
			'{1023, 0}, '{256, 256}};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) write_gains($urandom_range(0, 1023), $urandom_range(0, 1023));
			else write_gains(gains[ph][0], gains[ph][1]);
			foreach (rows[i]) begin
				want = (ph == 0 && rows[i].known) ? rows[i].want : boost_color(rows[i].color);
				send_color(rows[i].color, want);
			end
			for (int n = 0; n < N_RAND; n++) begin
				case ($urandom_range(0, 5))
					0: c = '{8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
						8'($urandom_range(0, 255))};
					1: begin
						c.r = $urandom_range(0, 255);
						c.g = c.r;
						c.b = c.r;
					end
					2: c = '{8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
						8'($urandom_range(0, 15))};
					default: c = '{8'($urandom), 8'($urandom), 8'($urandom)};
				endcase
				send_color(c, boost_color(c));
			end
			drain_pipeline();
		end

		$display("sent %0d colors over 6 gain settings, %0d results checked", n_sent, n_checked);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
